// ===== hw/rtl/jts_pkg.sv =====
// Shared types and constants of the JSON token scanner.
`default_nettype none

package jts_pkg;

    localparam int DEFAULT_VALUE_WIDTH = 32;
    localparam int DEFAULT_QUEUE_DEPTH = 4;

    localparam logic [31:0] NUMBER_MAX_RESET      = 32'd65535;
    localparam logic [8:0]  STRING_CAPACITY_RESET = 9'd16;

    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_QUOTE  = 8'h22;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;

    // Configuration register indexes.
    localparam logic CFG_NUMBER_MAX      = 1'b0;
    localparam logic CFG_STRING_CAPACITY = 1'b1;

    typedef enum logic [3:0] {
        KIND_LBRACE   = 4'd0,
        KIND_RBRACE   = 4'd1,
        KIND_LBRACKET = 4'd2,
        KIND_RBRACKET = 4'd3,
        KIND_COMMA    = 4'd4,
        KIND_COLON    = 4'd5,
        KIND_NUMBER   = 4'd6,
        KIND_CHAR     = 4'd7,
        KIND_STR_END  = 4'd8,
        KIND_ERROR    = 4'd9,
        KIND_END      = 4'd10
    } jts_kind_t;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_UNEXPECTED = 3'd1,
        ERR_CONTROL    = 3'd2,
        ERR_ESCAPE     = 3'd3,
        ERR_OVERFLOW   = 3'd4,
        ERR_UNTERM     = 3'd5
    } jts_err_t;

    // Slot positions inside one group of results.
    localparam int SLOT_NUM_END  = 0;  // number closed by a delimiter
    localparam int SLOT_MAIN     = 1;  // token, character, string end or error
    localparam int SLOT_PENDING  = 2;  // number or unterminated error at end of data
    localparam int SLOT_END      = 3;  // end token
    localparam int NUM_SLOTS     = 4;

    // All results caused by one input byte.
    typedef struct packed {
        logic [NUM_SLOTS-1:0] slot_valid;
        logic [31:0]          num_val;
        jts_kind_t            main_kind;
        logic [7:0]           main_char;
        logic                 main_trunc;
        jts_err_t             main_err;
        logic                 pending_err;
    } jts_group_t;

endpackage

`default_nettype wire

// ===== hw/rtl/jts_front.sv =====
// Front end: configuration registers, scan state and classification of each byte.
`default_nettype none

module jts_front
    import jts_pkg::*;
#(
    parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        take,
    input  wire logic [7:0]  in_byte,
    input  wire logic        end_of_data,
    output jts_group_t       grp,
    output logic             grp_push
);

    localparam int ACC_W = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
    localparam int CMP_W = 36;
    localparam logic [31:0] VALUE_MASK =
        (ACC_W >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ACC_W) - 64'd1);

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_NUMBER = 3'd1,
        MODE_STRING = 3'd2,
        MODE_ESCAPE = 3'd3,
        MODE_ERROR  = 3'd4
    } mode_t;

    logic [31:0]      number_max_reg;
    logic [8:0]       string_capacity_reg;
    mode_t            mode_reg, mode_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [8:0]       used_reg, used_next;
    logic             drop_reg, drop_next;

    logic [31:0]      limit;
    logic             is_digit, is_space;
    logic [3:0]       digit;
    logic [ACC_W+3:0] acc_step;
    logic             step_ok, first_ok;

    // Result of scanning the byte as if idle.
    logic             idle_emit;
    jts_kind_t        idle_kind;
    jts_err_t         idle_err;
    mode_t            idle_mode;
    logic             idle_open;

    logic             put_req;
    logic [7:0]       put_ch;
    logic [7:0]       esc_ch;
    logic             esc_ok;

    assign limit    = (number_max_reg > VALUE_MASK) ? VALUE_MASK : number_max_reg;
    assign is_digit = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);
    assign is_space = (in_byte == CHAR_SPACE) || ((in_byte >= 8'h09) && (in_byte <= 8'h0D));
    assign digit    = 4'(in_byte - CHAR_ZERO);
    // acc * 10 + digit; it fits the limit exactly when the checked add would.
    assign acc_step = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                      + (ACC_W + 4)'(digit);
    assign step_ok  = CMP_W'(acc_step) <= {4'b0000, limit};
    assign first_ok = {28'd0, digit} <= limit;

    always_comb
    begin
        esc_ok = 1'b1;
        unique case (in_byte)
            CHAR_QUOTE:  esc_ch = CHAR_QUOTE;
            CHAR_BSLASH: esc_ch = CHAR_BSLASH;
            8'h2F:       esc_ch = 8'h2F;
            8'h62:       esc_ch = 8'h08;
            8'h66:       esc_ch = 8'h0C;
            8'h6E:       esc_ch = 8'h0A;
            8'h72:       esc_ch = 8'h0D;
            8'h74:       esc_ch = 8'h09;
            default:
            begin
                esc_ch = 8'h00;
                esc_ok = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        idle_emit = 1'b0;
        idle_kind = KIND_ERROR;
        idle_err  = ERR_NONE;
        idle_mode = MODE_IDLE;
        idle_open = 1'b0;
        priority if (in_byte == 8'h7B)
        begin
            idle_emit = 1'b1;
            idle_kind = KIND_LBRACE;
        end
        else if (in_byte == 8'h7D)
        begin
            idle_emit = 1'b1;
            idle_kind = KIND_RBRACE;
        end
        else if (in_byte == 8'h5B)
        begin
            idle_emit = 1'b1;
            idle_kind = KIND_LBRACKET;
        end
        else if (in_byte == 8'h5D)
        begin
            idle_emit = 1'b1;
            idle_kind = KIND_RBRACKET;
        end
        else if (in_byte == 8'h2C)
        begin
            idle_emit = 1'b1;
            idle_kind = KIND_COMMA;
        end
        else if (in_byte == 8'h3A)
        begin
            idle_emit = 1'b1;
            idle_kind = KIND_COLON;
        end
        else if (in_byte == CHAR_QUOTE)
        begin
            if (string_capacity_reg == 9'd0)
            begin
                idle_emit = 1'b1;
                idle_err  = ERR_UNEXPECTED;
                idle_mode = MODE_ERROR;
            end
            else
            begin
                idle_mode = MODE_STRING;
                idle_open = 1'b1;
            end
        end
        else if (is_space)
        begin
            idle_mode = MODE_IDLE;
        end
        else if (is_digit)
        begin
            if (first_ok)
            begin
                idle_mode = MODE_NUMBER;
            end
            else
            begin
                idle_emit = 1'b1;
                idle_err  = ERR_OVERFLOW;
                idle_mode = MODE_ERROR;
            end
        end
        else
        begin
            idle_emit = 1'b1;
            idle_err  = ERR_UNEXPECTED;
            idle_mode = MODE_ERROR;
        end
    end

    always_comb
    begin
        mode_next  = mode_reg;
        acc_next   = acc_reg;
        used_next  = used_reg;
        drop_next  = drop_reg;
        put_req    = 1'b0;
        put_ch     = in_byte;
        grp        = '0;
        grp.main_kind = KIND_ERROR;
        grp.main_err  = ERR_NONE;

        unique case (mode_reg)
            MODE_IDLE, MODE_NUMBER:
            begin
                if ((mode_reg == MODE_NUMBER) && is_digit)
                begin
                    if (step_ok)
                    begin
                        acc_next = acc_step[ACC_W-1:0];
                    end
                    else
                    begin
                        grp.slot_valid[SLOT_MAIN] = 1'b1;
                        grp.main_kind             = KIND_ERROR;
                        grp.main_err              = ERR_OVERFLOW;
                        mode_next                 = MODE_ERROR;
                    end
                end
                else
                begin
                    // A delimiter closes the number, then is scanned on its own.
                    grp.slot_valid[SLOT_NUM_END] = (mode_reg == MODE_NUMBER);
                    grp.slot_valid[SLOT_MAIN]    = idle_emit;
                    grp.main_kind                = idle_kind;
                    grp.main_err                 = idle_err;
                    mode_next                    = idle_mode;
                    acc_next = (idle_mode == MODE_NUMBER) ? ACC_W'(digit) : '0;
                    if (idle_open)
                    begin
                        used_next = '0;
                        drop_next = 1'b0;
                    end
                end
            end
            MODE_STRING:
            begin
                priority if (in_byte == CHAR_QUOTE)
                begin
                    grp.slot_valid[SLOT_MAIN] = 1'b1;
                    grp.main_kind             = KIND_STR_END;
                    grp.main_trunc            = drop_reg;
                    mode_next                 = MODE_IDLE;
                    used_next                 = '0;
                    drop_next                 = 1'b0;
                end
                else if (in_byte < CHAR_SPACE)
                begin
                    grp.slot_valid[SLOT_MAIN] = 1'b1;
                    grp.main_kind             = KIND_ERROR;
                    grp.main_err              = ERR_CONTROL;
                    mode_next                 = MODE_ERROR;
                end
                else if (in_byte == CHAR_BSLASH)
                begin
                    mode_next = MODE_ESCAPE;
                end
                else
                begin
                    put_req = 1'b1;
                end
            end
            MODE_ESCAPE:
            begin
                if (esc_ok)
                begin
                    put_req = 1'b1;
                    put_ch  = esc_ch;
                end
                else
                begin
                    grp.slot_valid[SLOT_MAIN] = 1'b1;
                    grp.main_kind             = KIND_ERROR;
                    grp.main_err              = ERR_ESCAPE;
                    mode_next                 = MODE_ERROR;
                end
            end
            default:
            begin
                mode_next = MODE_ERROR;
            end
        endcase

        if (put_req)
        begin
            mode_next = MODE_STRING;
            if (({1'b0, used_reg} + 10'd1) < {1'b0, string_capacity_reg})
            begin
                used_next                 = used_reg + 9'd1;
                grp.slot_valid[SLOT_MAIN] = 1'b1;
                grp.main_kind             = KIND_CHAR;
                grp.main_char             = put_ch;
            end
            else
            begin
                drop_next = 1'b1;
            end
        end

        grp.num_val = grp.slot_valid[SLOT_NUM_END] ? 32'(acc_reg) : 32'(acc_next);

        if (end_of_data)
        begin
            if (mode_next == MODE_NUMBER)
            begin
                grp.slot_valid[SLOT_PENDING] = 1'b1;
            end
            else if ((mode_next == MODE_STRING) || (mode_next == MODE_ESCAPE))
            begin
                grp.slot_valid[SLOT_PENDING] = 1'b1;
                grp.pending_err              = 1'b1;
            end
            grp.slot_valid[SLOT_END] = 1'b1;
            mode_next = MODE_IDLE;
            acc_next  = '0;
            used_next = '0;
            drop_next = 1'b0;
        end
    end

    assign grp_push = take && (grp.slot_valid != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_max_reg      <= NUMBER_MAX_RESET;
            string_capacity_reg <= STRING_CAPACITY_RESET;
            mode_reg            <= MODE_IDLE;
            acc_reg             <= '0;
            used_reg            <= '0;
            drop_reg            <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == CFG_NUMBER_MAX)
                begin
                    number_max_reg <= cfg_data;
                end
                else
                begin
                    string_capacity_reg <= cfg_data[8:0];
                end
            end
            if (take)
            begin
                mode_reg <= mode_next;
                acc_reg  <= acc_next;
                used_reg <= used_next;
                drop_reg <= drop_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/jts_queue.sv =====
// Short queue of result groups between the front end and the back end.
`default_nettype none

module jts_queue
    import jts_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       wr_en,
    input  wire jts_group_t wr_data,
    output logic            full,
    input  wire logic       rd_en,
    output jts_group_t      rd_data,
    output logic            empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    jts_group_t       mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/jts_back.sv =====
// Back end: hands out the results of the oldest group one word per pop.
`default_nettype none

module jts_back
    import jts_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire jts_group_t  head,
    input  wire logic        q_empty,
    output logic             q_pop,
    output logic             empty,
    input  wire logic        pop,
    output logic [3:0]       token_kind,
    output logic [31:0]      token_value,
    output logic             truncated,
    output logic [2:0]       error_code,
    output logic             last_of_run
);

    logic [NUM_SLOTS-1:0] done_reg;
    logic [NUM_SLOTS-1:0] remain;
    logic [NUM_SLOTS-1:0] cur;
    logic                 take;

    assign remain      = head.slot_valid & ~done_reg;
    assign cur         = remain & (~remain + NUM_SLOTS'(1));
    assign last_of_run = ((remain & ~cur) == '0);
    assign empty       = q_empty;
    assign take        = pop && !q_empty;
    assign q_pop       = take && last_of_run;

    always_comb
    begin
        token_kind  = KIND_END;
        token_value = '0;
        truncated   = 1'b0;
        error_code  = ERR_NONE;
        priority if (cur[SLOT_NUM_END])
        begin
            token_kind  = KIND_NUMBER;
            token_value = head.num_val;
        end
        else if (cur[SLOT_MAIN])
        begin
            token_kind  = head.main_kind;
            token_value = (head.main_kind == KIND_CHAR) ? 32'(head.main_char) : '0;
            truncated   = head.main_trunc;
            error_code  = head.main_err;
        end
        else if (cur[SLOT_PENDING])
        begin
            if (head.pending_err)
            begin
                token_kind = KIND_ERROR;
                error_code = ERR_UNTERM;
            end
            else
            begin
                token_kind  = KIND_NUMBER;
                token_value = head.num_val;
            end
        end
        else
        begin
            token_kind = KIND_END;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= '0;
        end
        else if (take)
        begin
            done_reg <= last_of_run ? '0 : (done_reg | cur);
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/json_token_scanner.sv =====
// Top level of the JSON token scanner.
//
// Text bytes enter through a queue-style port: a byte is taken at a clock
// edge with push high and full low; end_of_data marks the last byte of a text.
// Tokens leave through a second queue-style port: while empty is low the
// oldest word is on token_kind, token_value, truncated, error_code and
// last_of_run, and pop high at a clock edge removes it.
// Registers are written through cfg_valid, cfg_index and cfg_data; cfg_ready
// is always high. Index 0 is the number maximum, index 1 the string capacity.
// The front end classifies one byte per cycle and stores all its words (up
// to three) as one group in a four-entry queue; the first word of a byte is
// visible once its group reaches the head of the queue. The back end delivers
// one word per pop, so the rate is one byte per cycle while each byte yields
// at most one word; a byte with several words needs a pop for each word.
// A stalled receiver fills the queue, then full rises and holds off input.
// Reset clears the scan state and the queue and loads the default register
// values (maximum 65535, capacity 16); no clearing pass is needed.
`default_nettype none

module json_token_scanner
    import jts_pkg::*;
#(
    parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH,
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  in_byte,
    input  wire logic        end_of_data,
    output logic             empty,
    input  wire logic        pop,
    output logic [3:0]       token_kind,
    output logic [31:0]      token_value,
    output logic             truncated,
    output logic [2:0]       error_code,
    output logic             last_of_run
);

    jts_group_t grp;
    jts_group_t head;
    logic       grp_push;
    logic       take;
    logic       q_empty;
    logic       q_pop;

    assign cfg_ready = 1'b1;
    assign take      = push && !full;

    jts_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .take        (take),
        .in_byte     (in_byte),
        .end_of_data (end_of_data),
        .grp         (grp),
        .grp_push    (grp_push)
    );

    jts_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (grp_push),
        .wr_data (grp),
        .full    (full),
        .rd_en   (q_pop),
        .rd_data (head),
        .empty   (q_empty)
    );

    jts_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .token_kind  (token_kind),
        .token_value (token_value),
        .truncated   (truncated),
        .error_code  (error_code),
        .last_of_run (last_of_run)
    );

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the JSON token scanner.
`timescale 1ns / 1ps

import jts_pkg::*;

typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_NUMBER,
    SCAN_STRING,
    SCAN_ESCAPE,
    SCAN_ERROR
} scan_mode_t;

typedef struct {
    jts_kind_t   kind;
    logic [31:0] value;
    logic        trunc;
    jts_err_t    err;
    logic        last;
} scan_token_t;

class token_scoreboard;
    scan_token_t expected_tokens[$];
    logic [31:0] number_max;
    logic [8:0]  string_capacity;
    scan_mode_t  mode;
    logic [31:0] accum;
    logic [8:0]  chars_used;
    logic        dropped;
    int          error_count;
    int          words_checked;

    function new();
        number_max      = NUMBER_MAX_RESET;
        string_capacity = STRING_CAPACITY_RESET;
        error_count     = 0;
        words_checked   = 0;
        reset_scan();
    endfunction

    function void reset_scan();
        mode       = SCAN_IDLE;
        accum      = '0;
        chars_used = '0;
        dropped    = 1'b0;
    endfunction

    function void set_register(logic index, logic [31:0] value);
        if (index == CFG_NUMBER_MAX)
            number_max = value;
        else
            string_capacity = value[8:0];
    endfunction

    function int outstanding();
        return expected_tokens.size();
    endfunction

    function void push_token(jts_kind_t kind, logic [31:0] value, logic trunc, jts_err_t err);
        scan_token_t tok;
        tok.kind  = kind;
        tok.value = value;
        tok.trunc = trunc;
        tok.err   = err;
        tok.last  = 1'b0;
        expected_tokens.push_back(tok);
    endfunction

    function void fail_scan(jts_err_t err);
        mode = SCAN_ERROR;
        push_token(KIND_ERROR, '0, 1'b0, err);
    endfunction

    function bit is_digit(logic [7:0] b);
        return b >= CHAR_ZERO && b <= CHAR_NINE;
    endfunction

    // The limit is number_max itself, since the value path is 32 bits wide.
    function bit add_digit(logic [7:0] b);
        longint unsigned limit;
        longint unsigned digit;
        longint unsigned acc;
        limit = number_max;
        digit = b - CHAR_ZERO;
        acc   = accum;
        if (digit > limit || acc > (limit - digit) / 10)
            return 1'b0;
        accum = 32'(acc * 10 + digit);
        return 1'b1;
    endfunction

    function void put_char(logic [7:0] ch);
        mode = SCAN_STRING;
        if (chars_used + 1 < string_capacity)
        begin
            chars_used++;
            push_token(KIND_CHAR, {24'd0, ch}, 1'b0, ERR_NONE);
        end
        else
            dropped = 1'b1;
    endfunction

    function void scan_idle(logic [7:0] b);
        case (b)
            "{": push_token(KIND_LBRACE, '0, 1'b0, ERR_NONE);
            "}": push_token(KIND_RBRACE, '0, 1'b0, ERR_NONE);
            "[": push_token(KIND_LBRACKET, '0, 1'b0, ERR_NONE);
            "]": push_token(KIND_RBRACKET, '0, 1'b0, ERR_NONE);
            ",": push_token(KIND_COMMA, '0, 1'b0, ERR_NONE);
            ":": push_token(KIND_COLON, '0, 1'b0, ERR_NONE);
            CHAR_QUOTE:
            begin
                if (string_capacity == 0)
                    fail_scan(ERR_UNEXPECTED);
                else
                begin
                    mode       = SCAN_STRING;
                    chars_used = '0;
                    dropped    = 1'b0;
                end
            end
            default:
            begin
                if (!(b == CHAR_SPACE || (b >= 8'h09 && b <= 8'h0D)))
                begin
                    if (is_digit(b))
                    begin
                        accum = '0;
                        if (add_digit(b))
                            mode = SCAN_NUMBER;
                        else
                            fail_scan(ERR_OVERFLOW);
                    end
                    else
                        fail_scan(ERR_UNEXPECTED);
                end
            end
        endcase
    endfunction

    function void note_byte(logic [7:0] b, logic eod);
        int first;
        first = expected_tokens.size();
        case (mode)
            SCAN_IDLE:
                scan_idle(b);
            SCAN_NUMBER:
            begin
                if (is_digit(b))
                begin
                    if (!add_digit(b))
                        fail_scan(ERR_OVERFLOW);
                end
                else
                begin
                    // The delimiter yields its own token after the number.
                    push_token(KIND_NUMBER, accum, 1'b0, ERR_NONE);
                    mode  = SCAN_IDLE;
                    accum = '0;
                    scan_idle(b);
                end
            end
            SCAN_STRING:
            begin
                if (b == CHAR_QUOTE)
                begin
                    push_token(KIND_STR_END, '0, dropped, ERR_NONE);
                    mode       = SCAN_IDLE;
                    chars_used = '0;
                    dropped    = 1'b0;
                end
                else if (b < CHAR_SPACE)
                    fail_scan(ERR_CONTROL);
                else if (b == CHAR_BSLASH)
                    mode = SCAN_ESCAPE;
                else
                    put_char(b);
            end
            SCAN_ESCAPE:
            begin
                case (b)
                    CHAR_QUOTE, CHAR_BSLASH, "/": put_char(b);
                    "b": put_char(8'h08);
                    "f": put_char(8'h0C);
                    "n": put_char(8'h0A);
                    "r": put_char(8'h0D);
                    "t": put_char(8'h09);
                    default: fail_scan(ERR_ESCAPE);
                endcase
            end
            default:
                mode = SCAN_ERROR;
        endcase

        if (eod)
        begin
            if (mode == SCAN_NUMBER)
                push_token(KIND_NUMBER, accum, 1'b0, ERR_NONE);
            else if (mode == SCAN_STRING || mode == SCAN_ESCAPE)
                push_token(KIND_ERROR, '0, 1'b0, ERR_UNTERM);
            push_token(KIND_END, '0, 1'b0, ERR_NONE);
            reset_scan();
        end

        if (expected_tokens.size() > first)
            expected_tokens[expected_tokens.size() - 1].last = 1'b1;
    endfunction

    function void report(string msg);
        error_count++;
        $display("MISMATCH at %0t: %s", $realtime, msg);
    endfunction

    function void check_token(logic [3:0] kind, logic [31:0] value, logic trunc,
                              logic [2:0] err, logic last);
        scan_token_t want;
        words_checked++;
        if (expected_tokens.size() == 0)
        begin
            report($sformatf("word %0d arrived with none pending: kind %0d value %0d",
                             words_checked, kind, value));
            return;
        end
        want = expected_tokens.pop_front();
        if (kind !== want.kind)
            report($sformatf("word %0d token_kind %0d, wanted %0d",
                             words_checked, kind, want.kind));
        if (value !== want.value)
            report($sformatf("word %0d token_value %0d, wanted %0d",
                             words_checked, value, want.value));
        if (trunc !== want.trunc)
            report($sformatf("word %0d truncated %0b, wanted %0b",
                             words_checked, trunc, want.trunc));
        if (err !== want.err)
            report($sformatf("word %0d error_code %0d, wanted %0d",
                             words_checked, err, want.err));
        if (last !== want.last)
            report($sformatf("word %0d last_of_run %0b, wanted %0b",
                             words_checked, last, want.last));
    endfunction
endclass

module tb;
    localparam int NUM_PHASES        = 6;
    localparam int PHASE_BYTES       = 40;
    localparam int LONG_STRING_CHARS = 40;
    localparam int SETTLE_CYCLES     = 6;
    localparam int unsigned CYCLE_LIMIT = 200000;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_valid   = 1'b0;
    logic        cfg_index   = 1'b0;
    logic [31:0] cfg_data    = '0;
    logic        push        = 1'b0;
    logic [7:0]  in_byte     = '0;
    logic        end_of_data = 1'b0;
    logic        pop         = 1'b0;
    logic        cfg_ready;
    logic        full;
    logic        empty;
    logic [3:0]  token_kind;
    logic [31:0] token_value;
    logic        truncated;
    logic [2:0]  error_code;
    logic        last_of_run;

    token_scoreboard board;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          bytes_sent     = 0;
    int unsigned cycle_count    = 0;

    logic [31:0] phase_number_max [NUM_PHASES] =
        '{NUMBER_MAX_RESET, 32'hFFFF_FFFF, 32'd9, 32'd0, 32'd5, 32'd65535};
    logic [8:0]  phase_capacity [NUM_PHASES] =
        '{STRING_CAPACITY_RESET, 9'd32, 9'd1, 9'd0, 9'd511, 9'd2};
    int          phase_send_idle  [NUM_PHASES] = '{0, 74, 0, 21, 0, 21};
    int          phase_recv_stall [NUM_PHASES] = '{0, 0, 74, 21, 0, 21};

    // Each entry is {end_of_data, byte}.
    logic [8:0] directed_text [26] = '{
        {1'b0, "{"}, {1'b0, CHAR_QUOTE}, {1'b0, 8'hFF}, {1'b0, CHAR_BSLASH},
        {1'b0, "n"}, {1'b0, CHAR_QUOTE}, {1'b0, ":"}, {1'b0, "1"},
        {1'b0, "2"}, {1'b0, "]"}, {1'b0, "["}, {1'b0, "}"},
        {1'b0, ","}, {1'b1, "7"},
        {1'b0, "6"}, {1'b0, "5"}, {1'b0, "5"}, {1'b0, "3"}, {1'b0, "6"},
        {1'b1, 8'h09},
        {1'b0, CHAR_QUOTE}, {1'b0, CHAR_BSLASH}, {1'b0, 8'h01}, {1'b1, 8'h00},
        {1'b0, CHAR_QUOTE}, {1'b1, CHAR_BSLASH}
    };

    json_token_scanner dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .full        (full),
        .in_byte     (in_byte),
        .end_of_data (end_of_data),
        .empty       (empty),
        .pop         (pop),
        .token_kind  (token_kind),
        .token_value (token_value),
        .truncated   (truncated),
        .error_code  (error_code),
        .last_of_run (last_of_run)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // Receiving side: check every word taken, then decide whether to stall.
    always @(posedge clk)
    begin
        if (pop && !empty)
            board.check_token(token_kind, token_value, truncated, error_code, last_of_run);
        pop <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task automatic send_byte(input logic [7:0] value, input logic last);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        push        <= 1'b1;
        in_byte     <= value;
        end_of_data <= last;
        @(posedge clk);
        while (full)
            @(posedge clk);
        board.note_byte(value, last);
        bytes_sent++;
    endtask

    // A byte that yields no word may still be in flight, hence the settle time.
    task automatic wait_drained();
        push <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_register(input logic index, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.set_register(index, value);
    endtask

    // Builds a mostly well-formed text out of random tokens, with some noise.
    task automatic send_random_text();
        logic [7:0] text [$];
        logic [7:0] ch;
        string      structural;
        string      escapes;
        int         pick;
        int         len;
        structural = "{}[],:";
        escapes    = "\"\\/bfnrt";
        repeat ($urandom_range(1, 6))
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                text.push_back(structural[$urandom_range(0, 5)]);
            else if (pick < 42)
            begin
                len = $urandom_range(0, 5);
                text.push_back((len == 5) ? CHAR_SPACE : 8'(8'h09 + len));
            end
            else if (pick < 64)
            begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 11) : $urandom_range(1, 4);
                repeat (len)
                    text.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
            end
            else if (pick < 92)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
                text.push_back(CHAR_QUOTE);
                repeat (len)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 72)
                    begin
                        ch = 8'($urandom_range(8'h20, 8'h7E));
                        if (ch == CHAR_QUOTE || ch == CHAR_BSLASH)
                            ch = "a";
                        text.push_back(ch);
                    end
                    else if (pick < 84)
                        text.push_back(8'($urandom_range(8'h80, 8'hFF)));
                    else if (pick < 97)
                    begin
                        text.push_back(CHAR_BSLASH);
                        text.push_back(escapes[$urandom_range(0, 7)]);
                    end
                    else if (pick < 99)
                    begin
                        text.push_back(CHAR_BSLASH);
                        text.push_back(8'($urandom_range(0, 255)));
                    end
                    else
                        text.push_back(8'($urandom_range(0, 8'h1F)));
                end
                if ($urandom_range(0, 19) != 0)
                    text.push_back(CHAR_QUOTE);
            end
            else
                text.push_back(8'($urandom_range(0, 255)));
        end
        foreach (text[i])
            send_byte(text[i], (i == text.size() - 1) ? ($urandom_range(0, 5) != 0)
                                                      : ($urandom_range(0, 99) < 2));
    endtask

    initial
    begin
        int phase_start;
        bit paused;
        board = new();
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase > 0)
            begin
                wait_drained();
                write_register(CFG_NUMBER_MAX, phase_number_max[phase]);
                write_register(CFG_STRING_CAPACITY, {23'd0, phase_capacity[phase]});
                cfg_valid <= 1'b0;
            end
            send_idle_pct  = phase_send_idle[phase];
            recv_stall_pct = phase_recv_stall[phase];

            if (phase == 0)
            begin
                foreach (directed_text[i])
                    send_byte(directed_text[i][7:0], directed_text[i][8]);
            end
            else if (phase == 1)
            begin
                // Overruns the buffer so the closing quote reports a drop.
                send_byte(CHAR_QUOTE, 1'b0);
                repeat (LONG_STRING_CHARS)
                    send_byte(8'($urandom_range(8'h61, 8'h7A)), 1'b0);
                send_byte(CHAR_QUOTE, 1'b1);
            end

            phase_start = bytes_sent;
            paused      = 1'b0;
            while (bytes_sent - phase_start < PHASE_BYTES)
            begin
                send_random_text();
                if (!paused && bytes_sent - phase_start >= PHASE_BYTES / 2)
                begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
            // Close the text so the next settings start from an idle scanner.
            send_byte(CHAR_SPACE, 1'b1);
        end

        wait_drained();
        if (board.error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
